// ===== rtl/cbp_eg_pkg.sv =====
// Package with the transaction types and the coded block pattern mapping tables.
`default_nettype none

package cbp_eg_pkg;

    localparam int unsigned NumPatterns = 48;
    localparam int unsigned PatternWidth = 6;
    localparam int unsigned CodeNumWidth = 6;
    localparam int unsigned CodeBitsWidth = 11;
    localparam int unsigned CodeLengthWidth = 4;

    typedef logic [PatternWidth-1:0] pattern_t;
    typedef logic [CodeNumWidth-1:0] code_num_t;

    typedef struct packed {
        pattern_t pattern;
        logic     is_inter;
    } cbp_item_t;

    typedef struct packed {
        logic [CodeBitsWidth-1:0]   code_bits;
        logic [CodeLengthWidth-1:0] code_length;
        logic                       out_of_range;
    } cbp_result_t;

    localparam code_num_t INTRA_MAP [0:NumPatterns-1] = '{
        6'd3,  6'd29, 6'd30, 6'd17, 6'd31, 6'd18, 6'd37, 6'd8,
        6'd32, 6'd38, 6'd19, 6'd9,  6'd20, 6'd10, 6'd11, 6'd2,
        6'd16, 6'd33, 6'd34, 6'd21, 6'd35, 6'd22, 6'd39, 6'd4,
        6'd36, 6'd40, 6'd23, 6'd5,  6'd24, 6'd6,  6'd7,  6'd1,
        6'd41, 6'd42, 6'd43, 6'd25, 6'd44, 6'd26, 6'd46, 6'd12,
        6'd45, 6'd47, 6'd27, 6'd13, 6'd28, 6'd14, 6'd15, 6'd0
    };

    localparam code_num_t INTER_MAP [0:NumPatterns-1] = '{
        6'd0,  6'd2,  6'd3,  6'd7,  6'd4,  6'd8,  6'd17, 6'd13,
        6'd5,  6'd18, 6'd9,  6'd14, 6'd10, 6'd15, 6'd16, 6'd11,
        6'd1,  6'd32, 6'd33, 6'd36, 6'd34, 6'd37, 6'd44, 6'd40,
        6'd35, 6'd45, 6'd38, 6'd41, 6'd39, 6'd42, 6'd43, 6'd19,
        6'd6,  6'd24, 6'd25, 6'd20, 6'd26, 6'd21, 6'd46, 6'd28,
        6'd27, 6'd47, 6'd22, 6'd29, 6'd23, 6'd30, 6'd31, 6'd12
    };

endpackage

`default_nettype wire

// ===== rtl/cbp_eg_stream_if.sv =====
// Valid/ready stream interface carrying one payload per transaction.
`default_nettype none

interface cbp_eg_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== rtl/cbp_expgolomb_mapped_encoder.sv =====
// Top level of the coded block pattern mapped Exp-Golomb encoder.
`default_nettype none

// The block takes one coded block pattern transaction per cycle while the
// output is not stalled and gives one codeword transaction for each. A
// transaction passes through an input register, a table lookup with a
// leading-one search, and a result register; both registers advance
// independently, so a held result does not stop the input side until both
// registers are full. Patterns of 48 and above give a zero codeword of
// length zero with out_of_range set.
module cbp_expgolomb_mapped_encoder
    import cbp_eg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    cbp_eg_stream_if.sink   item,
    cbp_eg_stream_if.source result
);

    logic        in_valid_reg;
    cbp_item_t   in_data_reg;
    logic        out_valid_reg;
    cbp_result_t out_data_reg;

    logic        out_take;
    logic        in_take;
    logic        in_range;
    pattern_t    lookup_idx;
    code_num_t   code_num;
    logic [CodeNumWidth-1:0] code_val;
    logic [2:0]  msb_pos;
    cbp_result_t out_data_next;

    assign out_take   = !out_valid_reg || result.ready;
    assign in_take    = !in_valid_reg || out_take;
    assign item.ready = in_take;

    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;

    always_comb
    begin
        in_range   = (in_data_reg.pattern < pattern_t'(NumPatterns));
        lookup_idx = in_range ? in_data_reg.pattern : '0;
        code_num   = in_data_reg.is_inter ? INTER_MAP[lookup_idx] : INTRA_MAP[lookup_idx];
        code_val   = code_num + code_num_t'(1);

        msb_pos = 3'd0;
        for (int i = 1; i < CodeNumWidth; i++)
        begin
            if (code_val[i])
            begin
                msb_pos = 3'(i);
            end
        end

        if (in_range)
        begin
            out_data_next.code_bits    = CodeBitsWidth'(code_val);
            out_data_next.code_length  = {msb_pos, 1'b1};
            out_data_next.out_of_range = 1'b0;
        end
        else
        begin
            out_data_next.code_bits    = '0;
            out_data_next.code_length  = '0;
            out_data_next.out_of_range = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= item.valid;
            end
            if (out_take)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && item.valid)
        begin
            in_data_reg <= item.payload;
        end
        if (out_take && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire
